FILE: hw/rtl/autofocus_sweep_sequencer_assert.svh
// Assertion macros shared by the autofocus sweep sequencer RTL.
// Plain text macros only; no package or module dependencies.
`ifndef AUTOFOCUS_SWEEP_SEQUENCER_ASSERT_SVH
`define AUTOFOCUS_SWEEP_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define AFSS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("afss: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define AFSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("afss: next-cycle check failed");

`endif

FILE: hw/rtl/afss_pkg.sv
// Shared types, widths and codes for the autofocus sweep sequencer.
// No dependencies; imported by every module of the block.
package afss_pkg;

  localparam int DEFAULT_POSITION_BITS = 20;

  localparam int START_W    = 20;
  localparam int STEP_W     = 16;
  localparam int COUNT_W    = 8;
  localparam int EXPO_W     = 22;
  localparam int BACKLASH_W = 16;
  localparam int HFR_W      = 16;
  localparam int MODE_W     = 3;
  localparam int CMD_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 22;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_START_POSITION   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_COUNT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXPOSURE_MS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BACKLASH         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_BEST_HFR = 3'd5;

  // Register values after reset. 25344 is 99.0 pixels in Q8.8.
  localparam logic [START_W-1:0]    RST_START_POSITION   = 20'd36000;
  localparam logic [STEP_W-1:0]     RST_STEP_SIZE        = 16'd50;
  localparam logic [COUNT_W-1:0]    RST_SWEEP_COUNT      = 8'd10;
  localparam logic [EXPO_W-1:0]     RST_EXPOSURE_MS      = 22'd2000;
  localparam logic [BACKLASH_W-1:0] RST_BACKLASH         = 16'd100;
  localparam logic [HFR_W-1:0]      RST_INITIAL_BEST_HFR = 16'd25344;

  // Input event codes.
  localparam logic [MODE_W-1:0] MODE_START      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RESET_DONE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POS_DONE   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_EXPO_DONE  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_HFR        = 3'd4;
  localparam logic [MODE_W-1:0] MODE_REFUSED    = 3'd5;
  localparam logic [MODE_W-1:0] MODE_ALERT      = 3'd6;
  localparam logic [MODE_W-1:0] MODE_ABORT      = 3'd7;

  // Output command codes.
  localparam logic [CMD_W-1:0] CMD_NONE        = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FRAME_RESET = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MOVE        = 3'd2;
  localparam logic [CMD_W-1:0] CMD_EXPOSE      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MEASURE     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_FINISHED    = 3'd5;
  localparam logic [CMD_W-1:0] CMD_ABORTED     = 3'd6;

  typedef struct packed {
    logic [START_W-1:0]    start_position;
    logic [STEP_W-1:0]     step_size;
    logic [COUNT_W-1:0]    sweep_count;
    logic [EXPO_W-1:0]     exposure_ms;
    logic [BACKLASH_W-1:0] backlash;
    logic [HFR_W-1:0]      initial_best_hfr;
  } cfg_t;

endpackage

FILE: hw/rtl/afss_cfg.sv
// Configuration register file of the autofocus sweep sequencer.
// Depends on afss_pkg for register indexes, widths and reset values.
module afss_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [afss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [afss_pkg::CFG_DATA_W-1:0]  cfg_data,
  output afss_pkg::cfg_t                   cfg
);
  import afss_pkg::*;

  cfg_t regs;

  // Writes to indexes past the last register are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.start_position   <= RST_START_POSITION;
      regs.step_size        <= RST_STEP_SIZE;
      regs.sweep_count      <= RST_SWEEP_COUNT;
      regs.exposure_ms      <= RST_EXPOSURE_MS;
      regs.backlash         <= RST_BACKLASH;
      regs.initial_best_hfr <= RST_INITIAL_BEST_HFR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_POSITION:   regs.start_position   <= cfg_data[START_W-1:0];
        REG_STEP_SIZE:        regs.step_size        <= cfg_data[STEP_W-1:0];
        REG_SWEEP_COUNT:      regs.sweep_count      <= cfg_data[COUNT_W-1:0];
        REG_EXPOSURE_MS:      regs.exposure_ms      <= cfg_data[EXPO_W-1:0];
        REG_BACKLASH:         regs.backlash         <= cfg_data[BACKLASH_W-1:0];
        REG_INITIAL_BEST_HFR: regs.initial_best_hfr <= cfg_data[HFR_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

FILE: hw/rtl/afss_core.sv
// Sequencer state and the per-event transition logic of the autofocus sweep.
// Depends on afss_pkg for codes, widths and the configuration struct.
module afss_core #(
  parameter int POSITION_BITS = afss_pkg::DEFAULT_POSITION_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [afss_pkg::MODE_W-1:0]   mode,
  input  logic [afss_pkg::HFR_W-1:0]    hfr,
  input  afss_pkg::cfg_t                cfg,
  output logic [afss_pkg::CMD_W-1:0]    command,
  output logic [POSITION_BITS-1:0]      target_position,
  output logic [afss_pkg::EXPO_W-1:0]   exposure_time,
  output logic [POSITION_BITS-1:0]      best_position,
  output logic [afss_pkg::HFR_W-1:0]    best_hfr,
  output logic [afss_pkg::COUNT_W-1:0]  sweep_index,
  output logic                          busy_res
);
  import afss_pkg::*;

  localparam logic [3:0] PH_IDLE               = 4'd0;
  localparam logic [3:0] PH_WAIT_RESET         = 4'd1;
  localparam logic [3:0] PH_WAIT_BACKLASH      = 4'd2;
  localparam logic [3:0] PH_WAIT_START         = 4'd3;
  localparam logic [3:0] PH_WAIT_EXPOSURE      = 4'd4;
  localparam logic [3:0] PH_WAIT_HFR           = 4'd5;
  localparam logic [3:0] PH_WAIT_NEXT          = 4'd6;
  localparam logic [3:0] PH_WAIT_BACKLASH_BEST = 4'd7;
  localparam logic [3:0] PH_WAIT_BEST          = 4'd8;
  localparam logic [3:0] PH_WAIT_EXPOSURE_BEST = 4'd9;

  localparam int PROD_W = COUNT_W + STEP_W;
  localparam int EXT_W  = ((POSITION_BITS > PROD_W) ? POSITION_BITS : PROD_W) + 1;
  localparam logic [EXT_W-1:0] POS_MAX_EXT =
    {{(EXT_W-POSITION_BITS){1'b0}}, {POSITION_BITS{1'b1}}};

  logic [3:0]               phase, phase_next;
  logic [COUNT_W-1:0]       point_counter, point_counter_next;
  logic [POSITION_BITS-1:0] sweep_position, sweep_position_next;
  logic [POSITION_BITS-1:0] best_pos, best_pos_next;
  logic [HFR_W-1:0]         best_hfr_q, best_hfr_next;

  logic [POSITION_BITS-1:0] start_sat;
  logic [COUNT_W-1:0]       pc_inc;
  logic [PROD_W-1:0]        offset;
  logic [POSITION_BITS-1:0] next_point;
  logic                     hfr_better;
  logic [POSITION_BITS-1:0] best_pos_upd;

  // Clamp a wide position to the top of the focuser range.
  function automatic logic [POSITION_BITS-1:0] sat_pos(input logic [EXT_W-1:0] v);
    logic [POSITION_BITS-1:0] r;
    r = v[POSITION_BITS-1:0];
    if (v > POS_MAX_EXT) r = POS_MAX_EXT[POSITION_BITS-1:0];
    return r;
  endfunction

  // Position minus an amount, clamped at zero.
  function automatic logic [POSITION_BITS-1:0] below(
    input logic [POSITION_BITS-1:0] pos,
    input logic [BACKLASH_W-1:0]    amount
  );
    logic [EXT_W-1:0] pos_ext;
    logic [EXT_W-1:0] amt_ext;
    logic [EXT_W-1:0] diff;
    pos_ext = EXT_W'(pos);
    amt_ext = EXT_W'(amount);
    diff    = pos_ext - amt_ext;
    return (amt_ext >= pos_ext) ? '0 : diff[POSITION_BITS-1:0];
  endfunction

  assign start_sat = sat_pos(EXT_W'(cfg.start_position));
  assign pc_inc    = point_counter + COUNT_W'(1);
  assign offset    = {{STEP_W{1'b0}}, pc_inc} * {{COUNT_W{1'b0}}, cfg.step_size};
  assign next_point = sat_pos(EXT_W'(start_sat) + EXT_W'(offset));
  assign hfr_better = hfr < best_hfr_q;
  assign best_pos_upd = hfr_better ? sweep_position : best_pos;

  always_comb begin
    phase_next          = phase;
    point_counter_next  = point_counter;
    sweep_position_next = sweep_position;
    best_pos_next       = best_pos;
    best_hfr_next       = best_hfr_q;
    command             = CMD_NONE;
    target_position     = '0;
    exposure_time       = '0;
    unique case (mode) inside
      MODE_REFUSED, MODE_ALERT, MODE_ABORT: begin
        if (phase != PH_IDLE) begin
          phase_next = PH_IDLE;
          command    = CMD_ABORTED;
        end
      end
      MODE_START: begin
        if (phase == PH_IDLE) begin
          point_counter_next  = '0;
          sweep_position_next = start_sat;
          best_pos_next       = start_sat;
          best_hfr_next       = cfg.initial_best_hfr;
          command             = CMD_FRAME_RESET;
          phase_next          = PH_WAIT_RESET;
        end
      end
      MODE_RESET_DONE: begin
        if (phase == PH_WAIT_RESET) begin
          command         = CMD_MOVE;
          target_position = below(start_sat, cfg.backlash);
          phase_next      = PH_WAIT_BACKLASH;
        end
      end
      MODE_POS_DONE: begin
        if (phase == PH_WAIT_BACKLASH) begin
          command         = CMD_MOVE;
          target_position = start_sat;
          phase_next      = PH_WAIT_START;
        end else if (phase == PH_WAIT_START || phase == PH_WAIT_NEXT) begin
          command       = CMD_EXPOSE;
          exposure_time = cfg.exposure_ms;
          phase_next    = PH_WAIT_EXPOSURE;
        end else if (phase == PH_WAIT_BACKLASH_BEST) begin
          command         = CMD_MOVE;
          target_position = best_pos;
          phase_next      = PH_WAIT_BEST;
        end else if (phase == PH_WAIT_BEST) begin
          command       = CMD_EXPOSE;
          exposure_time = cfg.exposure_ms;
          phase_next    = PH_WAIT_EXPOSURE_BEST;
        end
      end
      MODE_EXPO_DONE: begin
        if (phase == PH_WAIT_EXPOSURE) begin
          command    = CMD_MEASURE;
          phase_next = PH_WAIT_HFR;
        end else if (phase == PH_WAIT_EXPOSURE_BEST) begin
          command    = CMD_FINISHED;
          phase_next = PH_IDLE;
        end
      end
      MODE_HFR: begin
        if (phase == PH_WAIT_HFR) begin
          // Only a strictly lower HFR replaces the best point.
          if (hfr_better) begin
            best_hfr_next = hfr;
            best_pos_next = sweep_position;
          end
          command = CMD_MOVE;
          if (point_counter < cfg.sweep_count) begin
            point_counter_next  = pc_inc;
            sweep_position_next = next_point;
            target_position     = next_point;
            phase_next          = PH_WAIT_NEXT;
          end else begin
            target_position = below(best_pos_upd, cfg.backlash);
            phase_next      = PH_WAIT_BACKLASH_BEST;
          end
        end
      end
      default: ;
    endcase
  end

  assign best_position = best_pos_next;
  assign best_hfr      = best_hfr_next;
  assign sweep_index   = point_counter_next;
  assign busy_res      = (phase_next != PH_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      point_counter  <= '0;
      sweep_position <= '0;
      best_pos       <= '0;
      best_hfr_q     <= '1;
    end else if (step) begin
      phase          <= phase_next;
      point_counter  <= point_counter_next;
      sweep_position <= sweep_position_next;
      best_pos       <= best_pos_next;
      best_hfr_q     <= best_hfr_next;
    end
  end

endmodule

FILE: hw/rtl/autofocus_sweep_sequencer.sv
// Top level of the autofocus sweep sequencer: event input register, result register.
// Depends on afss_pkg, afss_cfg, afss_core and autofocus_sweep_sequencer_assert.svh.
//
//   Channel   Direction  Payload
//   s_*       in         tuser: mode; tdata: hfr
//   m_*       out        tuser: command; tdata: target, exposure, best point, index, busy
//   cfg_*     in         register index and write data, no read-back
//
// One item per cycle is sustained while m_tready is high. An accepted item waits in the input
// register until the output register is empty or drained, then its result loads there and
// m_tvalid rises. The transition (one 8x16 multiply, an add and a saturating compare) is
// combinational between the two registers. Reset (rst, synchronous) empties both and idles the
// sequencer. A stalled m_tready holds the result; an empty input register still takes an item.
`include "autofocus_sweep_sequencer_assert.svh"

module autofocus_sweep_sequencer #(
  parameter int POSITION_BITS = afss_pkg::DEFAULT_POSITION_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  // Event input.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [afss_pkg::MODE_W-1:0]     s_tuser,  // [2:0] mode
  input  logic [afss_pkg::HFR_W-1:0]      s_tdata,  // [15:0] hfr
  // Result output.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [afss_pkg::CMD_W-1:0]      m_tuser,  // [2:0] command
  // From bit 0: target_position, exposure_time, best_position, best_hfr, sweep_index,
  // busy_res, then zero fill to a whole byte.
  output logic [((2*POSITION_BITS + afss_pkg::EXPO_W + afss_pkg::HFR_W
                  + afss_pkg::COUNT_W + 1 + 7) / 8) * 8 - 1:0] m_tdata,
  // Configuration writes.
  input  logic                            cfg_we,
  input  logic [afss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [afss_pkg::CFG_DATA_W-1:0] cfg_data
);
  import afss_pkg::*;

  localparam int PACK_W = 2*POSITION_BITS + EXPO_W + HFR_W + COUNT_W + 1;
  localparam int DATA_W = ((PACK_W + 7) / 8) * 8;

  cfg_t cfg;

  // Input register.
  logic               s1_valid;
  logic [MODE_W-1:0]  s1_mode;
  logic [HFR_W-1:0]   s1_hfr;
  logic               advance;

  // Results of the transition for the event in the input register.
  logic [CMD_W-1:0]         r_command;
  logic [POSITION_BITS-1:0] r_target;
  logic [EXPO_W-1:0]        r_expo;
  logic [POSITION_BITS-1:0] r_best_pos;
  logic [HFR_W-1:0]         r_best_hfr;
  logic [COUNT_W-1:0]       r_index;
  logic                     r_busy;

  // Output register.
  logic                     out_valid;
  logic [CMD_W-1:0]         out_command;
  logic [POSITION_BITS-1:0] out_target;
  logic [EXPO_W-1:0]        out_expo;
  logic [POSITION_BITS-1:0] out_best_pos;
  logic [HFR_W-1:0]         out_best_hfr;
  logic [COUNT_W-1:0]       out_index;
  logic                     out_busy;

  // The held command is one that may come with an idle sequencer.
  logic                     out_cmd_terminal;

  afss_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The held event moves on when the output register is empty or is being drained;
  // that same edge commits the sequencer state.
  assign advance  = s1_valid && (!out_valid || m_tready);
  assign s_tready = !s1_valid || advance;

  afss_core #(
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .step            (advance),
    .mode            (s1_mode),
    .hfr             (s1_hfr),
    .cfg             (cfg),
    .command         (r_command),
    .target_position (r_target),
    .exposure_time   (r_expo),
    .best_position   (r_best_pos),
    .best_hfr        (r_best_hfr),
    .sweep_index     (r_index),
    .busy_res        (r_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s1_mode <= s_tuser;
      s1_hfr  <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_command  <= r_command;
      out_target   <= r_target;
      out_expo     <= r_expo;
      out_best_pos <= r_best_pos;
      out_best_hfr <= r_best_hfr;
      out_index    <= r_index;
      out_busy     <= r_busy;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_command;
  assign m_tdata  = DATA_W'({out_busy, out_index, out_best_hfr, out_best_pos,
                             out_expo, out_target});

  assign out_cmd_terminal = (out_command == CMD_NONE) || (out_command == CMD_FINISHED)
                            || (out_command == CMD_ABORTED);

  // Once idle, only the terminal reports or no command can be issued.
  `AFSS_ASSERT_IMPL(a_idle_cmd, clk, rst, out_valid && !out_busy, out_cmd_terminal)
  // A target is only reported with a move command.
  `AFSS_ASSERT_IMPL(a_target_move, clk, rst, out_valid && out_command != CMD_MOVE, out_target == '0)
  // An exposure time is only reported with an exposure command.
  `AFSS_ASSERT_IMPL(a_expo_cmd, clk, rst, out_valid && out_command != CMD_EXPOSE, out_expo == '0)
  // Every event that leaves the input register shows up as a result.
  `AFSS_ASSERT_NEXT(a_advance_out, clk, rst, advance, out_valid)

endmodule
